// ===== hw/rtl/rpn_stack_calculator_top_macros.svh =====
// Assertion macros for the RPN stack calculator.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define RPN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define RPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPN_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/rpn_calc_pkg.sv =====
package rpn_calc_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int WORD_W          = 32;
    localparam int STEP_W          = 6;

    // Opcodes carried in the input tuser field.
    localparam logic [2:0] OP_PUSH = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // Last step index of each serial operation (counted down to zero).
    localparam logic [STEP_W-1:0] ADD_LAST = 6'd31;
    localparam logic [STEP_W-1:0] MUL_LAST = 6'd31;
    localparam logic [STEP_W-1:0] DIV_LAST = 6'd47;

    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ADD,
        S_MUL,
        S_DIV,
        S_SAT,
        S_DONE
    } t_state;

    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    function automatic logic [WORD_W-1:0] abs32(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ===== hw/rtl/rpn_stack_calculator_top.sv =====
// One transaction at a time: a new one is accepted only once the last result has
// been committed to the output register. Add, subtract and multiply run 32 serial
// steps, divide 48 restoring quotient steps; push, unknown opcodes and division by
// zero skip the serial states. A finished result waits until the output is free.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending result;
// stack memory contents are not cleared, since no entry above the count is read.
`include "rpn_stack_calculator_top_macros.svh"

module rpn_stack_calculator_top
    import rpn_calc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [31:0] top_value, [39:32] stack_depth,
                                        // [41:40] status, [47:42] zero
);

    // The count must hold the depth itself; the address only the entries.
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    // Operand stack. The top entry is also mirrored in r_tos so that an
    // operator only needs one memory read, for the left operand.
    logic [WORD_W-1:0] r_mem [STACK_DEPTH];

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_new_cnt;
    logic [WORD_W-1:0]   r_tos;
    logic [WORD_W-1:0]   r_rd_data;
    logic [2:0]          r_op;

    // Serial datapath: r_a and r_b are the operand shift registers, r_q collects
    // result or quotient bits, r_acc is the multiply accumulator or the
    // division remainder.
    logic [WORD_W-1:0]   r_a, r_b, r_q;
    logic [WORD_W:0]     r_acc;
    logic                r_c, r_sa, r_sb, r_neg, r_hi;
    logic [STEP_W-1:0]   r_step;

    logic [WORD_W-1:0]   r_res;
    logic [1:0]          r_status;
    logic                r_wr;

    logic                r_out_valid;
    logic [47:0]         r_out_data;

    logic                w_accept, w_commit, w_sub;
    logic [WORD_W-1:0]   w_left, w_right;
    logic [CNT_W-1:0]    w_op_cnt, w_rd_cnt, w_wr_cnt;
    logic [CNT_W+7:0]    w_depth_ext;
    logic                w_sbit, w_cout, w_ext;
    logic                w_msub;
    logic [WORD_W+1:0]   w_mext, w_maddend, w_msum;
    logic [WORD_W:0]     w_rsh;
    logic [WORD_W+1:0]   w_diff;
    logic                w_qbit;
    logic                w_ovf;
    logic [WORD_W-1:0]   w_sat_res;
    logic [WORD_W-1:0]   w_top;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Operands as seen at load time; a missing operand counts as zero.
    assign w_right  = (r_count != '0) ? r_tos : '0;
    assign w_left   = (r_count >= CNT_W'(2)) ? r_rd_data : '0;
    assign w_op_cnt = (r_count >= CNT_W'(2)) ? (r_count - CNT_W'(1)) : CNT_W'(1);
    assign w_rd_cnt = r_count - CNT_W'(2);
    assign w_wr_cnt = r_new_cnt - CNT_W'(1);
    assign w_sub    = (r_op == OP_SUB);

    // Bit-serial add and subtract, least significant bit first. Subtraction
    // inverts the right operand and starts with a carry of one.
    assign w_sbit = r_a[0] ^ (r_b[0] ^ w_sub) ^ r_c;
    assign w_cout = (r_a[0] & (r_b[0] ^ w_sub)) | (r_c & (r_a[0] ^ (r_b[0] ^ w_sub)));
    // Bit 32 of the exact sum, to detect overflow.
    assign w_ext  = r_sa ^ r_sb ^ r_c;

    // Serial-parallel signed multiply: one multiplier bit per cycle, the sign
    // bit of the multiplier having negative weight, so the last step subtracts.
    assign w_msub    = r_b[0] && (r_step == '0);
    assign w_mext    = {{2{r_a[WORD_W-1]}}, r_a};
    assign w_maddend = (r_b[0] ? w_mext : '0) ^ {(WORD_W+2){w_msub}};
    assign w_msum    = {r_acc[WORD_W], r_acc} + w_maddend + {{(WORD_W+1){1'b0}}, w_msub};

    // Restoring division on magnitudes: one dividend bit enters the remainder
    // each cycle, 32 bits of |left| followed by 16 zero bits.
    assign w_rsh  = {r_acc[WORD_W-1:0], r_a[WORD_W-1]};
    assign w_diff = {1'b0, w_rsh} - {2'b00, r_b};
    assign w_qbit = !w_diff[WORD_W+1];

    // Saturation of the finished serial result.
    always_comb begin
        w_ovf     = 1'b0;
        w_sat_res = r_res;
        case (r_op)
            OP_ADD, OP_SUB: begin
                w_ovf     = (w_ext != r_q[WORD_W-1]);
                w_sat_res = w_ovf ? (w_ext ? SAT_NEG : SAT_POS) : r_q;
            end
            OP_MUL: begin
                // Product is {r_acc[31:0], r_q}; bits 63 to 47 must agree.
                w_ovf     = !((&r_acc[31:15]) || !(|r_acc[31:15]));
                w_sat_res = w_ovf ? (r_acc[31] ? SAT_NEG : SAT_POS)
                                  : {r_acc[15:0], r_q[31:16]};
            end
            OP_DIV: begin
                // A quotient of 2^31 is only representable when negative.
                w_ovf     = r_hi || (r_q[WORD_W-1] && !(r_neg && (r_q[WORD_W-2:0] == '0)));
                w_sat_res = w_ovf ? (r_neg ? SAT_NEG : SAT_POS)
                                  : (r_neg ? (~r_q + 32'd1) : r_q);
            end
            default: begin
                w_ovf     = 1'b0;
                w_sat_res = r_res;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                case (r_op)
                    OP_ADD, OP_SUB: n_state = S_ADD;
                    OP_MUL:         n_state = S_MUL;
                    OP_DIV:         n_state = (w_right == '0) ? S_DONE : S_DIV;
                    default:        n_state = S_DONE;
                endcase
            end
            S_ADD, S_MUL, S_DIV: begin
                if (r_step == '0) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake outputs. A finished result is committed as soon as the output
    // register is free or is being emptied in the same cycle.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        w_commit      = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= r_new_cnt;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_depth_ext = {8'd0, r_new_cnt};
    assign w_top       = (r_new_cnt == '0) ? '0 : r_res;

    // Datapath and stack memory.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op      <= s_axis_tuser;
                    r_a       <= s_axis_tdata;
                    r_rd_data <= r_mem[w_rd_cnt[ADDR_W-1:0]];
                end
            end
            S_LOAD: begin
                r_status  <= ST_OK;
                r_wr      <= 1'b1;
                r_new_cnt <= w_op_cnt;
                r_res     <= r_tos;
                case (r_op)
                    OP_PUSH: begin
                        if (r_count == FULL_CNT) begin
                            r_status  <= ST_FULL;
                            r_wr      <= 1'b0;
                            r_new_cnt <= r_count;
                        end else begin
                            r_res     <= r_a;
                            r_new_cnt <= r_count + CNT_W'(1);
                        end
                    end
                    OP_ADD, OP_SUB: begin
                        r_a    <= w_left;
                        r_b    <= w_right;
                        r_c    <= w_sub;
                        r_sa   <= w_left[WORD_W-1];
                        r_sb   <= w_right[WORD_W-1] ^ w_sub;
                        r_step <= ADD_LAST;
                    end
                    OP_MUL: begin
                        r_a    <= w_left;
                        r_b    <= w_right;
                        r_acc  <= '0;
                        r_step <= MUL_LAST;
                    end
                    OP_DIV: begin
                        if (w_right == '0) begin
                            // Division by zero saturates toward the dividend's sign; a zero dividend gives zero.
                            r_status <= ST_DIVZERO;
                            if (w_left == '0) begin
                                r_res <= '0;
                            end else begin
                                r_res <= w_left[WORD_W-1] ? SAT_NEG : SAT_POS;
                            end
                        end else begin
                            r_a    <= abs32(w_left);
                            r_b    <= abs32(w_right);
                            r_acc  <= '0;
                            r_q    <= '0;
                            r_hi   <= 1'b0;
                            r_neg  <= w_left[WORD_W-1] ^ w_right[WORD_W-1];
                            r_step <= DIV_LAST;
                        end
                    end
                    default: begin
                        r_wr      <= 1'b0;
                        r_new_cnt <= r_count;
                    end
                endcase
            end
            S_ADD: begin
                r_a    <= {1'b0, r_a[WORD_W-1:1]};
                r_b    <= {1'b0, r_b[WORD_W-1:1]};
                r_q    <= {w_sbit, r_q[WORD_W-1:1]};
                r_c    <= w_cout;
                r_step <= r_step - STEP_W'(1);
            end
            S_MUL: begin
                r_acc  <= w_msum[WORD_W+1:1];
                r_q    <= {w_msum[0], r_q[WORD_W-1:1]};
                r_b    <= {1'b0, r_b[WORD_W-1:1]};
                r_step <= r_step - STEP_W'(1);
            end
            S_DIV: begin
                r_acc  <= {1'b0, (w_qbit ? w_diff[WORD_W-1:0] : w_rsh[WORD_W-1:0])};
                r_a    <= {r_a[WORD_W-2:0], 1'b0};
                r_q    <= {r_q[WORD_W-2:0], w_qbit};
                r_hi   <= r_hi | r_q[WORD_W-1];
                r_step <= r_step - STEP_W'(1);
            end
            S_SAT: begin
                r_res <= w_sat_res;
                if (w_ovf) begin
                    r_status <= ST_SAT;
                end
            end
            S_DONE: begin
                if (w_commit) begin
                    if (r_wr) begin
                        r_mem[w_wr_cnt[ADDR_W-1:0]] <= r_res;
                        r_tos                       <= r_res;
                    end
                    r_out_data <= {6'd0, r_status, w_depth_ext[7:0], w_top};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // The entry count never passes the stack depth.
    `RPN_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT,
        "stack count beyond depth")
    // A stack write always lands on an entry inside the stack.
    `RPN_ASSERT(a_write_in_range, i_clk, i_rst_n,
        (r_state == S_DONE && r_wr) |-> (r_new_cnt != '0 && r_new_cnt <= FULL_CNT),
        "stack write out of range")
    // A new result only appears when an item finishes.
    `RPN_ASSERT(a_out_from_commit, i_clk, i_rst_n,
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE),
        "result without finished item")
    // Reset leaves the block idle with no pending result.
    `RPN_ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> (r_state == S_IDLE && !m_axis_tvalid),
        "reset did not clear control state")

endmodule

// ===== tb/sv/rpn_calc_checker.sv =====
module rpn_calc_checker
    import rpn_calc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [31:0] top_value, [39:32] stack_depth,
                                        // [41:40] status, [47:42] zero
    output int          o_fail_count,
    output int          o_outstanding,
    output int          o_checked
);

    typedef struct packed {
        logic [31:0] top_value;
        logic [7:0]  stack_depth;
        logic [1:0]  status;
    } t_calc_result;

    localparam logic signed [63:0] WIDE_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] WIDE_MIN = -64'sh0000_0000_8000_0000;

    // Shadow copy of the operand stack; entries above the count are never read.
    logic [31:0]  shadow_stack [STACK_DEPTH_DEF];
    int unsigned  shadow_count;
    t_calc_result expected_results [$];
    int           fail_total;
    int           checked_total;

    // An empty stack yields a zero operand.
    function automatic logic [31:0] pop_operand();
        logic [31:0] word;
        word = '0;
        if (shadow_count != 0) begin
            shadow_count--;
            word = shadow_stack[shadow_count];
        end
        return word;
    endfunction

    function automatic t_calc_result evaluate_item(input logic [2:0]  opcode,
                                                   input logic [31:0] operand);
        t_calc_result       res;
        logic [31:0]        right_w;
        logic [31:0]        left_w;
        logic [31:0]        outcome;
        logic signed [63:0] lhs;
        logic signed [63:0] rhs;
        logic signed [63:0] wide;
        res.status = ST_OK;
        case (opcode)
            OP_PUSH: begin
                if (shadow_count >= STACK_DEPTH_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_stack[shadow_count] = operand;
                    shadow_count++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                right_w = pop_operand();
                left_w  = pop_operand();
                lhs     = {{32{left_w[31]}}, left_w};
                rhs     = {{32{right_w[31]}}, right_w};
                wide    = '0;
                case (opcode)
                    OP_ADD: wide = lhs + rhs;
                    OP_SUB: wide = lhs - rhs;
                    // Floor shift of the full product keeps the Q16.16 point.
                    OP_MUL: wide = (lhs * rhs) >>> 16;
                    default: begin
                        if (rhs != 0) begin
                            wide = (lhs <<< 16) / rhs;
                        end
                    end
                endcase
                if (opcode == OP_DIV && rhs == 0) begin
                    res.status = ST_DIVZERO;
                    outcome = (lhs > 0) ? SAT_POS : (lhs < 0) ? SAT_NEG : '0;
                end else if (wide > WIDE_MAX) begin
                    res.status = ST_SAT;
                    outcome    = SAT_POS;
                end else if (wide < WIDE_MIN) begin
                    res.status = ST_SAT;
                    outcome    = SAT_NEG;
                end else begin
                    outcome = wide[31:0];
                end
                shadow_stack[shadow_count] = outcome;
                shadow_count++;
            end
            default: begin
            end
        endcase
        res.top_value   = (shadow_count != 0) ? shadow_stack[shadow_count - 1] : '0;
        res.stack_depth = shadow_count[7:0];
        return res;
    endfunction

    function automatic int field_mismatch(input string       field,
                                          input logic [31:0] want,
                                          input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
                     $time, field, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_calc_result predicted;
        int           wrong;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_results.delete();
        end else begin
            // The result leaving now always belongs to an earlier transaction.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no transaction waiting for it, actual 0x%h",
                             $time, m_axis_tdata);
                    fail_total++;
                end else begin
                    predicted = expected_results.pop_front();
                    wrong = field_mismatch("top_value", predicted.top_value,
                                           m_axis_tdata[31:0])
                          + field_mismatch("stack_depth", 32'(predicted.stack_depth),
                                           32'(m_axis_tdata[39:32]))
                          + field_mismatch("status", 32'(predicted.status),
                                           32'(m_axis_tdata[41:40]));
                    if (wrong != 0) begin
                        fail_total++;
                    end
                    checked_total++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(evaluate_item(s_axis_tuser, s_axis_tdata));
            end
        end
        o_fail_count  <= fail_total;
        o_checked     <= checked_total;
        o_outstanding <= expected_results.size();
    end

endmodule

// ===== tb/sv/tb_rpn_stack_calculator_top.sv =====
// Top of the calculator testbench. It generates the clock and reset, drives the
// operation stream, stalls the result stream, and gives the verdict. All prediction
// and comparison is done by the checker instantiated beside the block.
module tb_rpn_stack_calculator_top
    import rpn_calc_pkg::*;
();

    localparam int RESET_CYCLES    = 12;
    // No transaction on either side for this many cycles means the block is stuck.
    // The longest legitimate quiet spell is the deliberate hold-off below.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 300;
    localparam int ITEM_TARGET     = 1750;
    // Extra time after the last result, so that any late output is still seen.
    localparam int DRAIN_CYCLES    = 80;

    // Opcodes the block must leave without effect.
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    // A few Q16.16 constants for the directed part.
    localparam logic [31:0] Q_ONE       = 32'h0001_0000;
    localparam logic [31:0] Q_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_HALF      = 32'h0000_8000;
    localparam logic [31:0] Q_SEVEN     = 32'h0007_0000;
    localparam logic [31:0] Q_MINUS_TWO = 32'hFFFE_0000;
    localparam logic [31:0] LSB_ONLY    = 32'h0000_0001;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [31:0] push_value
    logic [2:0]  s_axis_tuser  = OP_PUSH; // [2:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [31:0] top_value, [39:32] stack_depth,
                                        // [41:40] status, [47:42] zero

    int fail_count;
    int outstanding;
    int checked;
    int idle_cycles;
    int burst_left;
    int push_items;
    int arith_items;
    int ignored_items;

    rpn_stack_calculator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    rpn_calc_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    always #6 i_clk = ~i_clk;

    // Reset is held for a fixed number of cycles once, at the start, and never again.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Burst lengths are mostly short, but now and then a long burst gives a stretch
    // in which the sender never idles.
    function automatic int next_burst();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                           : $urandom_range(1, 12);
    endfunction

    // Gaps are usually short; the occasional long one can outlast even a divide, so that
    // idle time lands on every phase of the block's serial work.
    function automatic int next_gap();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(20, 70)
                                           : $urandom_range(1, 6);
    endfunction

    // Operands mix the extremes, zero (to provoke division by zero), small fractional
    // values that keep products in range, whole numbers and fully random words.
    function automatic logic [31:0] rand_operand();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: begin
                case ($urandom_range(0, 5))
                    0: return SAT_POS;
                    1: return SAT_NEG;
                    2: return LSB_ONLY;
                    3: return '1;
                    4: return Q_ONE;
                    default: return Q_MINUS_ONE;
                endcase
            end
            2, 3, 4: return {{11{raw[20]}}, raw[20:0]};
            5: return {{8{raw[7]}}, raw[7:0], 16'h0000};
            default: return raw;
        endcase
    endfunction

    function automatic logic [2:0] rand_arith();
        case ($urandom_range(0, 3))
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    // Offers one transaction and waits for it to be taken. Valid is lowered only when
    // a burst ends, so back-to-back transactions keep it high without a glitch.
    task automatic send_item(input logic [2:0] opcode, input logic [31:0] operand);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= opcode;
        s_axis_tdata  <= operand;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (opcode == OP_PUSH) begin
            push_items++;
        end else if (opcode >= OP_UNUSED_FIRST) begin
            ignored_items++;
        end else begin
            arith_items++;
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (next_gap()) @(posedge i_clk);
            burst_left = next_burst();
        end
    endtask

    // Pushes well past the stack's capacity, so that pushes are dropped on a full
    // stack, then works the stack back down with a long run of operators.
    task automatic run_fill();
        repeat ($urandom_range(STACK_DEPTH_DEF + 2, STACK_DEPTH_DEF + 12)) begin
            send_item(($urandom_range(0, 19) == 0) ? OP_UNUSED_FIRST : OP_PUSH,
                      rand_operand());
        end
        repeat ($urandom_range(STACK_DEPTH_DEF - 28, STACK_DEPTH_DEF + 12)) begin
            send_item(rand_arith(), $urandom);
        end
    endtask

    // A short well-formed expression: a few operands followed by about as many
    // operators, so the depth wanders but does not drift towards the limit.
    task automatic run_expression();
        int operands;
        operands = $urandom_range(1, 3);
        repeat (operands) send_item(OP_PUSH, rand_operand());
        repeat ($urandom_range(operands - 1, operands + 1)) send_item(rand_arith(), $urandom);
    endtask

    // Noise: any opcode, the unused ones included, with any data.
    task automatic run_noise();
        repeat ($urandom_range(5, 20)) send_item(3'($urandom_range(0, 7)), rand_operand());
    endtask

    initial begin : stimulus
        wait (i_rst_n);
        burst_left = next_burst();

        // Division with both operands missing gives zero with the divide flag.
        send_item(OP_DIV, $urandom);
        // An unused opcode must leave the stack as it was.
        send_item(OP_UNUSED_FIRST, $urandom);
        // Positive overflow of a sum.
        send_item(OP_PUSH, SAT_POS);
        send_item(OP_PUSH, SAT_POS);
        send_item(OP_ADD, '0);
        // Negative overflow of a difference.
        send_item(OP_PUSH, SAT_NEG);
        send_item(OP_PUSH, LSB_ONLY);
        send_item(OP_SUB, '1);
        // The most negative value times minus one overflows.
        send_item(OP_PUSH, SAT_NEG);
        send_item(OP_PUSH, Q_MINUS_ONE);
        send_item(OP_MUL, '0);
        // Division by zero of a positive and of a negative dividend.
        send_item(OP_PUSH, Q_ONE);
        send_item(OP_PUSH, '0);
        send_item(OP_DIV, '1);
        send_item(OP_PUSH, Q_MINUS_ONE);
        send_item(OP_PUSH, '0);
        send_item(OP_DIV, '0);
        // An ordinary fractional quotient, then one that overflows.
        send_item(OP_PUSH, Q_SEVEN);
        send_item(OP_PUSH, Q_MINUS_TWO);
        send_item(OP_DIV, '0);
        send_item(OP_PUSH, SAT_NEG);
        send_item(OP_PUSH, Q_HALF);
        send_item(OP_DIV, '1);
        send_item(OP_UNUSED_LAST, '1);

        // Reach a full stack early, then mix episodes until enough work has been done.
        run_fill();
        while (push_items + arith_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       run_fill();
                1, 2:    run_noise();
                default: run_expression();
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // The checker's count of waiting results is registered and lags the last
        // transaction, so look at it only from the next edge on.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d push, %0d arithmetic and %0d unused-opcode transactions;",
                 push_items, arith_items, ignored_items);
        $display("%0d results were checked, including full-stack and divide-by-zero cases.",
                 checked);
        if (fail_count == 0) begin
            $display("** rpn_stack_calculator_top: PASSED **");
        end else begin
            $display("** rpn_stack_calculator_top: FAILED **");
        end
        $finish;
    end

    // The result side accepts in random stretches. Once, after a good number of
    // results, it holds off for a long spell while the sender keeps offering, so the
    // block is left holding a finished result and has to stall its input.
    initial begin : result_sink
        logic held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (!held && checked >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30)) begin
                    @(posedge i_clk);
                end
                m_axis_tready <= 1'b0;
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 10)) begin
                    @(posedge i_clk);
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction happens on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results still due",
                         $time, idle_cycles, outstanding);
                $display("** rpn_stack_calculator_top: FAILED **");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== rpn_stack_calculator_top.f =====
+incdir+hw/rtl
hw/rtl/rpn_calc_pkg.sv
hw/rtl/rpn_stack_calculator_top.sv
tb/sv/rpn_calc_checker.sv
tb/sv/tb_rpn_stack_calculator_top.sv
